[rtl/core/ring_of_records_offset_lookup_defines.svh]
// Assertion macros shared by the ring of records offset lookup RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef RING_OF_RECORDS_OFFSET_LOOKUP_DEFINES_SVH
`define RING_OF_RECORDS_OFFSET_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ROOL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ROOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ROOL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ROOL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/rool_pkg.sv]
// Package for the ring of records offset lookup: field widths, codes and types.
// Depends on nothing; used by rool_slot_ram and ring_of_records_offset_lookup.
`default_nettype none

package rool_pkg;

	localparam int unsigned HANDLE_W       = 32;
	localparam int unsigned LEN_W          = 24;
	localparam int unsigned OFFS_W         = 28;
	localparam int unsigned SLOT_OUT_W     = 4;
	localparam int unsigned SLOT_COUNT_DEF = 16;

	typedef enum logic [0:0] {
		CMD_ADD  = 1'b0,
		CMD_FIND = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
	} rec_t;

endpackage

`default_nettype wire

[rtl/core/rool_slot_ram.sv]
// Slot store of the ring: one write port, one read port with registered data.
// Depends on rool_pkg for the record type.
`default_nettype none

module rool_slot_ram #(
	parameter int unsigned DEPTH = rool_pkg::SLOT_COUNT_DEF,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  rool_pkg::rec_t    wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output rool_pkg::rec_t    rd_data
);
	import rool_pkg::*;

	rec_t mem_q [DEPTH];
	rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[rtl/core/ring_of_records_offset_lookup.sv]
// Top level of the ring of records offset lookup: sequencer, ring pointers, walk unit.
// Depends on rool_pkg, rool_slot_ram and the assertion macro header.
//
// Usage: a command word is taken at a rising edge where start is high and busy
// is low. An add word (command 0) stores record_handle and record_length at the
// write index in that cycle and gives no result; busy never rises for it.
// When the ring is full the oldest record is overwritten and the ring stays full.
// A find word (command 1) walks the stored records from oldest to newest, one
// slot per cycle through the single slot memory read port and one shared
// add-and-compare unit, looking for the record that holds byte_offset in the
// concatenated data. Records with a zero handle or zero length are skipped.
// The result word appears on found, slot_index, hit_handle, hit_length and
// offset_in_record, marked by done, which is high for a single cycle. A find
// stays busy until its walk hits or runs past the newest stored record; done
// follows in the next cycle, during which a new word may already be taken.
// The receiver cannot stall: it must take each result word in its done cycle.
// Reset empties the ring (both indexes zero, not full); slot contents are not
// cleared and are never read before written.
`default_nettype none

`include "ring_of_records_offset_lookup_defines.svh"

module ring_of_records_offset_lookup #(
	parameter int unsigned SLOT_COUNT = rool_pkg::SLOT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [rool_pkg::HANDLE_W-1:0]  record_handle,
	input  logic [rool_pkg::LEN_W-1:0]     record_length,
	input  logic [rool_pkg::OFFS_W-1:0]    byte_offset,
	output logic                           done,
	output logic                           found,
	output logic [rool_pkg::SLOT_OUT_W-1:0] slot_index,
	output logic [rool_pkg::HANDLE_W-1:0]  hit_handle,
	output logic [rool_pkg::LEN_W-1:0]     hit_length,
	output logic [rool_pkg::LEN_W-1:0]     offset_in_record
);
	import rool_pkg::*;

	// Slot numbers, and a count that can also hold SLOT_COUNT itself.
	localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
	localparam int unsigned CNT_W  = SLOT_W + 1;
	// The running byte total of all records never exceeds SLOT_COUNT full lengths.
	localparam int unsigned RUN_W  = LEN_W + SLOT_W;
	// Compare width covers both the running sum plus one length and the offset.
	localparam int unsigned CMP_W  = (RUN_W + 1 > OFFS_W) ? RUN_W + 1 : OFFS_W;
	localparam logic [CNT_W-1:0]  SC_EXT   = CNT_W'(SLOT_COUNT);
	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOT_COUNT - 1);

	state_t state_q, state_d;

	// Ring pointers.
	logic [SLOT_W-1:0] wr_idx_q, rd_idx_q;
	logic              full_q;
	logic [SLOT_W-1:0] wr_idx_inc, rd_idx_inc;

	// Walk state of the running find.
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  iss_k_q;
	logic              pend_q;
	logic [SLOT_W-1:0] chk_slot_q;
	logic [RUN_W-1:0]  running_q;
	logic [OFFS_W-1:0] target_q;

	logic              add_go, find_go;
	logic              rd_en;
	logic [CNT_W-1:0]  rd_sum;
	logic [SLOT_W-1:0] rd_addr;
	logic [CNT_W-1:0]  occ_sum;
	logic [CNT_W-1:0]  occ_cnt;
	rec_t              wr_rec, rd_rec;
	logic              rec_live;
	logic [CMP_W-1:0]  end_sum;
	logic [CMP_W-1:0]  inner_off;
	logic              below_end;
	logic              fin_hit, fin_miss;
	logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

	logic                  done_q;
	logic                  found_q;
	logic [SLOT_OUT_W-1:0] slot_index_q;
	logic [HANDLE_W-1:0]   hit_handle_q;
	logic [LEN_W-1:0]      hit_length_q;
	logic [LEN_W-1:0]      offset_q;

	assign busy    = (state_q != ST_IDLE);
	assign add_go  = start && !busy && (command == CMD_ADD);
	assign find_go = start && !busy && (command == CMD_FIND);

	assign wr_idx_inc = (wr_idx_q == SLOT_MAX) ? '0 : wr_idx_q + 1'b1;
	assign rd_idx_inc = (rd_idx_q == SLOT_MAX) ? '0 : rd_idx_q + 1'b1;

	// Number of stored records: the whole ring when full, else the pointer gap.
	assign occ_sum = {1'b0, wr_idx_q} + SC_EXT - {1'b0, rd_idx_q};
	always_comb begin
		if (full_q) begin
			occ_cnt = SC_EXT;
		end else if (occ_sum >= SC_EXT) begin
			occ_cnt = occ_sum - SC_EXT;
		end else begin
			occ_cnt = occ_sum;
		end
	end

	// Slot visited at walk step k is the oldest slot plus k, wrapped once.
	assign rd_sum  = {1'b0, rd_idx_q} + iss_k_q;
	assign rd_addr = (rd_sum >= SC_EXT) ? SLOT_W'(rd_sum - SC_EXT) : rd_sum[SLOT_W-1:0];

	assign wr_rec.handle = record_handle;
	assign wr_rec.length = record_length;

	rool_slot_ram #(
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (add_go),
		.wr_addr (wr_idx_q),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_rec)
	);

	// Shared add-and-compare unit: does the target byte fall inside this record?
	assign rec_live  = (rd_rec.handle != '0) && (rd_rec.length != '0);
	assign end_sum   = CMP_W'(running_q) + CMP_W'(rd_rec.length);
	assign below_end = CMP_W'(target_q) < end_sum;
	assign inner_off = CMP_W'(target_q) - CMP_W'(running_q);

	// Sequencer: next state and the controls of the walk.
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		fin_hit  = 1'b0;
		fin_miss = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (find_go) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				rd_en = (iss_k_q != cnt_q);
				if (pend_q && rec_live && below_end) begin
					fin_hit = 1'b1;
					state_d = ST_IDLE;
				end else if (!pend_q && !rd_en) begin
					fin_miss = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The write index moves on each add. The read index only moves once full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			full_q   <= 1'b0;
		end else if (add_go) begin
			wr_idx_q <= wr_idx_inc;
			if (full_q) begin
				rd_idx_q <= rd_idx_inc;
			end else if (wr_idx_inc == rd_idx_q) begin
				full_q <= 1'b1;
			end
		end
	end

	// Walk control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_k_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin_hit || fin_miss;
			if (find_go) begin
				iss_k_q <= '0;
				pend_q  <= 1'b0;
			end else begin
				pend_q <= rd_en;
				if (rd_en) begin
					iss_k_q <= iss_k_q + 1'b1;
				end
			end
		end
	end

	// Walk data path.
	always_ff @(posedge clk) begin
		if (find_go) begin
			cnt_q     <= occ_cnt;
			target_q  <= byte_offset;
			running_q <= '0;
		end else if (pend_q && rec_live) begin
			running_q <= RUN_W'(end_sum);
		end
		if (rd_en) begin
			chk_slot_q <= rd_addr;
		end
	end

	// Result word; a miss reports all fields as zero.
	assign slot_ext = {{SLOT_OUT_W{1'b0}}, chk_slot_q};

	always_ff @(posedge clk) begin
		if (fin_hit) begin
			found_q      <= 1'b1;
			slot_index_q <= slot_ext[SLOT_OUT_W-1:0];
			hit_handle_q <= rd_rec.handle;
			hit_length_q <= rd_rec.length;
			offset_q     <= inner_off[LEN_W-1:0];
		end else if (fin_miss) begin
			found_q      <= 1'b0;
			slot_index_q <= '0;
			hit_handle_q <= '0;
			hit_length_q <= '0;
			offset_q     <= '0;
		end
	end

	assign done             = done_q;
	assign found            = found_q;
	assign slot_index       = slot_index_q;
	assign hit_handle       = hit_handle_q;
	assign hit_length       = hit_length_q;
	assign offset_in_record = offset_q;

	// A result word follows the last cycle of every walk.
	`ROOL_ASSERT_NEXT(a_done_after_walk, clk, arst_n, state_q == ST_WALK && state_d == ST_IDLE, done_q)
	`ROOL_ASSERT_NOW(a_done_from_walk, clk, arst_n, done_q, $past(state_q) == ST_WALK)
	// The walk never issues more reads than there are stored records.
	`ROOL_ASSERT_NOW(a_issue_bound, clk, arst_n, state_q == ST_WALK, iss_k_q <= cnt_q)
	// A full ring has its write index caught up with its read index.
	`ROOL_ASSERT_NOW(a_full_ptrs, clk, arst_n, full_q, wr_idx_q == rd_idx_q)
	// A miss reports zero in every field.
	`ROOL_ASSERT_NOW(a_miss_zero, clk, arst_n, done_q && !found_q, slot_index_q == '0 && hit_handle_q == '0 && hit_length_q == '0 && offset_q == '0)

endmodule

`default_nettype wire
